[rtl/npd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the nearest pathway direction block.
package npd_pkg;

	localparam int CMD_W  = 2;
	localparam int IDX_W  = 3;
	localparam int SLOT_W = 2;
	localparam int PCNT_W = 4;
	localparam int MAXD_W = 13;
	localparam int DIR_W  = 4;

	localparam logic [MAXD_W-1:0] MAXD_RESET = 13'd100;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_FIRST = 2'd1,
		CMD_LAST  = 2'd2
	} cmd_t;

	localparam logic [SLOT_W-1:0] SLOT_ENTRY0 = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_ENTRY1 = 2'd1;
	localparam logic [SLOT_W-1:0] SLOT_EXIT   = 2'd2;

	localparam logic CFG_PATH_COUNT   = 1'b0;
	localparam logic CFG_MAX_DISTANCE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// control that travels with each word along the root chain
	typedef struct packed {
		logic valid;
		logic exit;
	} cell_ctl_t;

endpackage

[rtl/npd_root_cell.sv]
`timescale 1ns / 1ps
// One digit step of the square root chain: retires one root bit per cycle.
module npd_root_cell import npd_pkg::*; #(
	parameter int ROOT_W = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctl_t             ctl_in,
	input  logic [2*ROOT_W-1:0]   rad_in,
	input  logic [ROOT_W+1:0]     rem_in,
	input  logic [ROOT_W-1:0]     root_in,
	output cell_ctl_t             ctl_out,
	output logic [2*ROOT_W-1:0]   rad_out,
	output logic [ROOT_W+1:0]     rem_out,
	output logic [ROOT_W-1:0]     root_out
);

	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic              ge;
	cell_ctl_t         ctl_q;
	logic [2*ROOT_W-1:0] rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;

	// bring down the next two radicand bits and try root*4+1
	assign rem_sh = {rem_in[ROOT_W-1:0], rad_in[2*ROOT_W-1 -: 2]};
	assign trial  = {root_in, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad_in[2*ROOT_W-3:0], 2'b00};
		rem_q  <= ge ? (rem_sh - trial) : rem_sh;
		root_q <= {root_in[ROOT_W-2:0], ge};
	end

	assign ctl_out  = ctl_q;
	assign rad_out  = rad_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;

endmodule

[rtl/nearest_pathway_direction.sv]
`timescale 1ns / 1ps
// Load and first-box items give no result; a last-box item starts a classification whose result
// comes from one table read per point of the n pathways in use and the square root cell chain,
// one cell per root bit (QW root bits, 18 by default).
// Throughput: one classification at a time; the input stalls until its result is registered.
// Reset clears control and configuration (path_count 0, max_distance 100) and the first
// center; pathway points are undefined until loaded.
module nearest_pathway_direction import npd_pkg::*; #(
	parameter int MAX_PATHS  = 8,
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [IDX_W-1:0]      path_index,
	input  logic [SLOT_W-1:0]     point_slot,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [COORD_BITS-1:0] box_width,
	input  logic [COORD_BITS-1:0] box_height,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DIR_W-1:0]      direction,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [MAXD_W-1:0]     cfg_data
);

	localparam int CTR_W = COORD_BITS + 1;
	localparam int SQ_W  = 2 * CTR_W + 1;
	localparam int RAD_BITS = SQ_W + 2 * FRAC_BITS;
	localparam int QW    = (RAD_BITS + 1) / 2;
	localparam int RADW  = 2 * QW;
	localparam int MEM_D = 3 * MAX_PATHS;
	localparam int AW    = $clog2(MEM_D);
	localparam int CNTW  = $clog2(MEM_D + 1);
	localparam int CMPW  = (QW + 1 > MAXD_W + FRAC_BITS + 1) ? QW + 1 : MAXD_W + FRAC_BITS + 1;

	// configuration
	logic [PCNT_W-1:0] path_count_q;
	logic [MAXD_W-1:0] max_distance_q;

	// control
	state_t            state_q, state_nxt;
	logic              accept;
	cmd_t              cmd_e;
	logic [PCNT_W-1:0] n_sat;
	logic [PCNT_W-1:0] n_q;
	logic [CNTW-1:0]   limit_q;
	logic [CNTW-1:0]   addr_q;
	logic [SLOT_W-1:0] slot_q;
	logic              issue;
	logic              start;
	logic              pair_done;
	logic              out_load;

	// centers
	logic [CTR_W-1:0]  box_cx, box_cy;
	logic [CTR_W-1:0]  first_cx_q, first_cy_q;
	logic [CTR_W-1:0]  last_cx_q, last_cy_q;

	// pathway table
	logic [2*COORD_BITS-1:0] pt_mem_q [MEM_D];
	logic              ld_hit;
	logic [7:0]        ld_addr_full;

	// datapath pipeline
	logic                    rd_valid_s1;
	logic [SLOT_W-1:0]       rd_slot_s1;
	logic [2*COORD_BITS-1:0] rd_data_s1;
	logic [2*COORD_BITS-1:0] e0_q;
	logic [COORD_BITS:0]     mid_x_sum, mid_y_sum;
	cell_ctl_t               ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [COORD_BITS-1:0]   pt_x_s2, pt_y_s2;
	logic [CTR_W-1:0]        ref_x, ref_y, px, py;
	logic [CTR_W-1:0]        dx_s3, dy_s3;
	logic [2*CTR_W-1:0]      sqx_s4, sqy_s4;
	logic [RADW-1:0]         rad_s5;

	// root chain
	cell_ctl_t               chain_ctl  [QW+1];
	logic [RADW-1:0]         chain_rad  [QW+1];
	logic [QW+1:0]           chain_rem  [QW+1];
	logic [QW-1:0]           chain_root [QW+1];
	logic [QW-1:0]           chain_busy;

	// selection
	logic [QW-1:0]           first_d_q;
	logic [CMPW-1:0]         dist_sum;
	logic [CMPW-1:0]         best_q;
	logic [DIR_W-1:0]        dir_q;
	logic [PCNT_W-1:0]       pair_cnt_q;
	logic                    out_valid_q;
	logic [DIR_W-1:0]        direction_q;
	logic                    pipe_busy;

	assign cmd_e    = cmd_t'(cmd);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign start    = accept && (cmd_e == CMD_LAST);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_count_q   <= '0;
			max_distance_q <= MAXD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PATH_COUNT:   path_count_q   <= cfg_data[PCNT_W-1:0];
				CFG_MAX_DISTANCE: max_distance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// box center: left/top edge plus half the size, rounded down
	assign box_cx = CTR_W'(pos_x) + CTR_W'(box_width >> 1);
	assign box_cy = CTR_W'(pos_y) + CTR_W'(box_height >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cx_q <= '0;
			first_cy_q <= '0;
		end else if (accept && (cmd_e == CMD_FIRST)) begin
			first_cx_q <= box_cx;
			first_cy_q <= box_cy;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			last_cx_q <= box_cx;
			last_cy_q <= box_cy;
		end
	end

	// table write: drop slots past the exit point and pathways beyond the table
	assign ld_hit = accept && (cmd_e == CMD_LOAD) && (point_slot <= SLOT_EXIT)
		&& (7'(path_index) < 7'(MAX_PATHS));
	assign ld_addr_full = 8'({path_index, 1'b0}) + 8'(path_index) + 8'(point_slot);

	always_ff @(posedge clk) begin
		if (ld_hit) begin
			pt_mem_q[ld_addr_full[AW-1:0]] <= {pos_y, pos_x};
		end
		rd_data_s1 <= pt_mem_q[addr_q[AW-1:0]];
	end

	// sequencer: one table point per cycle, pathways in order
	assign n_sat = (7'(path_count_q) > 7'(MAX_PATHS)) ? PCNT_W'(MAX_PATHS) : path_count_q;
	assign issue = (state_q == ST_RUN) && (addr_q != limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			limit_q     <= '0;
			addr_q      <= '0;
			slot_q      <= SLOT_ENTRY0;
			rd_valid_s1 <= 1'b0;
			rd_slot_s1  <= SLOT_ENTRY0;
		end else begin
			rd_valid_s1 <= issue;
			rd_slot_s1  <= slot_q;
			if (start) begin
				n_q     <= n_sat;
				limit_q <= CNTW'(6'({n_sat, 1'b0}) + 6'(n_sat));
				addr_q  <= '0;
				slot_q  <= SLOT_ENTRY0;
			end else if (issue) begin
				addr_q <= addr_q + 1'b1;
				slot_q <= (slot_q == SLOT_EXIT) ? SLOT_ENTRY0 : slot_q + 1'b1;
			end
		end
	end

	// stage 2: entry midpoint or exit point
	assign mid_x_sum = (COORD_BITS+1)'(e0_q[COORD_BITS-1:0])
		+ (COORD_BITS+1)'(rd_data_s1[COORD_BITS-1:0]);
	assign mid_y_sum = (COORD_BITS+1)'(e0_q[2*COORD_BITS-1:COORD_BITS])
		+ (COORD_BITS+1)'(rd_data_s1[2*COORD_BITS-1:COORD_BITS]);

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && (rd_slot_s1 == SLOT_ENTRY0)) begin
			e0_q <= rd_data_s1;
		end
		if (rd_slot_s1 == SLOT_EXIT) begin
			pt_x_s2 <= rd_data_s1[COORD_BITS-1:0];
			pt_y_s2 <= rd_data_s1[2*COORD_BITS-1:COORD_BITS];
		end else begin
			pt_x_s2 <= mid_x_sum[COORD_BITS:1];
			pt_y_s2 <= mid_y_sum[COORD_BITS:1];
		end
	end

	// stage 3: absolute differences against the matching center
	assign ref_x = ctl_s2.exit ? last_cx_q : first_cx_q;
	assign ref_y = ctl_s2.exit ? last_cy_q : first_cy_q;
	assign px    = CTR_W'(pt_x_s2);
	assign py    = CTR_W'(pt_y_s2);

	always_ff @(posedge clk) begin
		dx_s3  <= (ref_x > px) ? ref_x - px : px - ref_x;
		dy_s3  <= (ref_y > py) ? ref_y - py : py - ref_y;
		sqx_s4 <= dx_s3 * dx_s3;
		sqy_s4 <= dy_s3 * dy_s3;
		rad_s5 <= RADW'(SQ_W'(sqx_s4) + SQ_W'(sqy_s4)) << (2 * FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s2.valid <= rd_valid_s1 && (rd_slot_s1 != SLOT_ENTRY0);
			ctl_s2.exit  <= (rd_slot_s1 == SLOT_EXIT);
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// square root chain, one root bit per cell
	assign chain_ctl[0]  = ctl_s5;
	assign chain_rad[0]  = rad_s5;
	assign chain_rem[0]  = '0;
	assign chain_root[0] = '0;

	for (genvar g = 0; g < QW; g++) begin : g_cell
		npd_root_cell #(
			.ROOT_W(QW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (chain_ctl[g]),
			.rad_in   (chain_rad[g]),
			.rem_in   (chain_rem[g]),
			.root_in  (chain_root[g]),
			.ctl_out  (chain_ctl[g+1]),
			.rad_out  (chain_rad[g+1]),
			.rem_out  (chain_rem[g+1]),
			.root_out (chain_root[g+1])
		);
		assign chain_busy[g] = chain_ctl[g+1].valid;
	end

	// pair up entry and exit distances, keep the earliest smallest sum
	assign dist_sum  = CMPW'(first_d_q) + CMPW'(chain_root[QW]);
	assign pair_done = chain_ctl[QW].valid && chain_ctl[QW].exit
		&& ((pair_cnt_q + 1'b1) == n_q);

	always_ff @(posedge clk) begin
		if (chain_ctl[QW].valid && !chain_ctl[QW].exit) begin
			first_d_q <= chain_root[QW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			dir_q      <= '0;
			pair_cnt_q <= '0;
		end else if (start) begin
			best_q     <= CMPW'(max_distance_q) << (FRAC_BITS + 1);
			dir_q      <= '0;
			pair_cnt_q <= '0;
		end else if (chain_ctl[QW].valid && chain_ctl[QW].exit) begin
			pair_cnt_q <= pair_cnt_q + 1'b1;
			if (dist_sum < best_q) begin
				best_q <= dist_sum;
				dir_q  <= DIR_W'(pair_cnt_q + 1'b1);
			end
		end
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_RUN;
			end
			ST_RUN: begin
				if ((n_q == '0) || pair_done) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			direction_q <= dir_q;
		end
	end

	assign out_valid = out_valid_q;
	assign direction = direction_q;

	assign pipe_busy = rd_valid_s1 || ctl_s2.valid || ctl_s3.valid || ctl_s4.valid
		|| ctl_s5.valid || (|chain_busy);

	a_pipe_empty_outside_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> !pipe_busy)
		else $error("datapath holds a word outside a classification");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised without a finished classification");

	a_direction_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (direction_q <= $past(n_q)))
		else $error("direction beyond pathways in use");

	a_addr_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (addr_q <= limit_q))
		else $error("table read address overran pathway count");

	a_pair_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_ctl[QW].valid && chain_ctl[QW].exit) |-> (pair_cnt_q < n_q))
		else $error("more distance pairs than pathways in use");

endmodule
